@@ src/vector_polar_accumulator_macros.svh @@
// Assertion macros used by vpa_ctrl of the vector polar accumulator RTL.
// The macros expect signals named clock and reset in the scope where they are used.
`ifndef VECTOR_POLAR_ACCUMULATOR_MACROS_SVH
`define VECTOR_POLAR_ACCUMULATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VPA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VPA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/vpa_pkg.sv @@
// Shared types and constants of the vector polar accumulator.
// Used by vpa_ctrl, vpa_datapath and the top level; depends on nothing.
package vpa_pkg;

   localparam int GUARD     = 24;
   localparam int XW        = 60;
   localparam int ZW        = 36;
   localparam int TABLE_LEN = 30;
   localparam int IDX_W     = 5;

   localparam logic [2:0] CMD_LOAD_XY    = 3'd0;
   localparam logic [2:0] CMD_LOAD_POLAR = 3'd1;
   localparam logic [2:0] CMD_ADD        = 3'd2;
   localparam logic [2:0] CMD_SUB        = 3'd3;
   localparam logic [2:0] CMD_SCALE      = 3'd4;

   localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic [29:0]          GAIN_Q30    = 30'd652032874;
   localparam logic signed [ZW-1:0] ANGLE_MAX   = 36'sd205887;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LATCH,
      OP_LOAD_XY,
      OP_ADD,
      OP_SUB,
      OP_SC_X,
      OP_SC_Y,
      OP_SC_W,
      OP_RT_MUL,
      OP_RT_INIT,
      OP_RT_ITER,
      OP_RT_DONE,
      OP_VC_INIT,
      OP_VC_ITER,
      OP_GN_HI,
      OP_GN_LO,
      OP_GN_SUM,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type        op;
      logic [IDX_W-1:0] iter;
   } dp_ctrl_type;

   typedef struct packed {
      logic [2:0] cmd;
   } dp_stat_type;

   // Arctangent of 2^-i in Q.30 radians.
   function automatic logic signed [ZW-1:0] atan_q30(input logic [IDX_W-1:0] i);
      logic [31:0] v;
      case (i)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         5'd24: v = 32'h0000003F;
         5'd25: v = 32'h0000001F;
         5'd26: v = 32'h0000000F;
         5'd27: v = 32'h00000008;
         5'd28: v = 32'h00000004;
         5'd29: v = 32'h00000002;
         default: v = 32'h0;
      endcase
      return $signed({4'b0, v});
   endfunction

endpackage

@@ src/vpa_ctrl.sv @@
// Controller state machine of the vector polar accumulator.
// Depends on vpa_pkg and the assertion macros header.
`include "vector_polar_accumulator_macros.svh"

module vpa_ctrl #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output vpa_pkg::dp_ctrl_type ctrl,
   input  vpa_pkg::dp_stat_type stat
);
   import vpa_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_EXEC, S_SC_Y, S_SC_W, S_RT_INIT, S_RT_ITER, S_RT_DONE,
      S_VC_INIT, S_VC_ITER, S_GN_HI, S_GN_LO, S_GN_SUM, S_OUT
   } state_type;

   localparam logic [IDX_W-1:0] LAST_ITER = IDX_W'(CORDIC_ITERATIONS - 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             req_tready_ff, req_tready_in;
   logic             rsp_tvalid_ff, rsp_tvalid_in;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      req_tready_in = req_tready_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      ctrl.op       = OP_NONE;
      ctrl.iter     = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready_ff) begin
               ctrl.op       = OP_LATCH;
               req_tready_in = 1'b0;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_VC_INIT;
            case (stat.cmd)
               CMD_LOAD_XY: ctrl.op = OP_LOAD_XY;
               CMD_ADD:     ctrl.op = OP_ADD;
               CMD_SUB:     ctrl.op = OP_SUB;
               CMD_SCALE: begin
                  ctrl.op  = OP_SC_X;
                  state_in = S_SC_Y;
               end
               CMD_LOAD_POLAR: begin
                  ctrl.op  = OP_RT_MUL;
                  state_in = S_RT_INIT;
               end
               default: ctrl.op = OP_NONE;
            endcase
         end
         S_SC_Y: begin
            ctrl.op  = OP_SC_Y;
            state_in = S_SC_W;
         end
         S_SC_W: begin
            ctrl.op  = OP_SC_W;
            state_in = S_VC_INIT;
         end
         S_RT_INIT: begin
            ctrl.op  = OP_RT_INIT;
            cnt_in   = '0;
            state_in = S_RT_ITER;
         end
         S_RT_ITER: begin
            ctrl.op = OP_RT_ITER;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ITER) begin
               state_in = S_RT_DONE;
            end
         end
         S_RT_DONE: begin
            ctrl.op  = OP_RT_DONE;
            state_in = S_VC_INIT;
         end
         S_VC_INIT: begin
            ctrl.op  = OP_VC_INIT;
            cnt_in   = '0;
            state_in = S_VC_ITER;
         end
         S_VC_ITER: begin
            ctrl.op = OP_VC_ITER;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ITER) begin
               state_in = S_GN_HI;
            end
         end
         S_GN_HI: begin
            ctrl.op  = OP_GN_HI;
            state_in = S_GN_LO;
         end
         S_GN_LO: begin
            ctrl.op  = OP_GN_LO;
            state_in = S_GN_SUM;
         end
         S_GN_SUM: begin
            ctrl.op  = OP_GN_SUM;
            state_in = S_OUT;
         end
         S_OUT: begin
            // The result register is reloaded only once the previous result is gone.
            if (!rsp_tvalid_ff || rsp_tready) begin
               ctrl.op       = OP_OUT;
               rsp_tvalid_in = 1'b1;
               req_tready_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         req_tready_ff <= 1'b1;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         req_tready_ff <= req_tready_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign req_tready = req_tready_ff;
   assign rsp_tvalid = rsp_tvalid_ff;

   `VPA_ASSERT_NEXT(a_accept_starts, req_tvalid && req_tready_ff, state_ff == S_EXEC,
                    "accepted request did not start execution")
   `VPA_ASSERT_SAME(a_no_overwrite, rsp_tvalid_ff && !rsp_tready, ctrl.op != OP_OUT,
                    "pending result overwritten")
   `VPA_ASSERT_SAME(a_iter_range, state_ff == S_VC_ITER || state_ff == S_RT_ITER,
                    cnt_ff <= LAST_ITER, "iteration count out of range")
   `VPA_ASSERT_NEXT(a_out_valid, ctrl.op == OP_OUT, rsp_tvalid_ff && req_tready_ff,
                    "result load did not raise valid")

endmodule

@@ src/vpa_datapath.sv @@
// Datapath of the vector polar accumulator: stored vector, shared multiplier,
// one CORDIC stage used for rotation and vectoring, and the result register. Uses vpa_pkg.
module vpa_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [151:0]         req_tdata,
   input  logic [2:0]           req_tuser,
   input  vpa_pkg::dp_ctrl_type ctrl,
   output vpa_pkg::dp_stat_type stat,
   output logic [119:0]         rsp_tdata,
   output logic                 rsp_tuser
);
   import vpa_pkg::*;

   function automatic logic [32:0] clamp32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         return {1'b1, 32'h7FFFFFFF};
      end else if (v < -66'sd2147483648) begin
         return {1'b1, 32'h80000000};
      end
      return {1'b0, v[31:0]};
   endfunction

   // Latched request.
   logic [2:0]         cmd_ff;
   logic signed [31:0] ix_ff, iy_ff, sf_ff;
   logic signed [18:0] ang_ff;
   logic [30:0]        len_ff;

   // Stored vector and working registers.
   logic signed [31:0]   vec_x_ff, vec_x_in, vec_y_ff, vec_y_in;
   logic                 sat_ff, sat_in;
   logic signed [XW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [ZW-1:0] cz_ff, cz_in;
   logic                 neg_ff, neg_in, zero_ff, zero_in;
   logic signed [65:0]   prod_ff, prod_in;
   logic [63:0]          acc_ff, acc_in;

   // Result register.
   logic [31:0] ox_ff, oy_ff, olen_ff;
   logic [18:0] oang_ff;
   logic        osat_ff;

   logic signed [32:0]   mul_a, mul_b;
   logic signed [65:0]   sc_round, rt_rx, rt_ry;
   logic signed [XW-1:0] rt_x, rt_y, xs, ys, vx0, vy0;
   logic signed [ZW-1:0] at, z0, zc, zr;
   logic signed [32:0]   sum_x, sum_y;
   logic [32:0]          cl_x, cl_y, cl_s;
   logic [63:0]          lsum;
   logic [39:0]          lshift;
   logic [31:0]          len_res;
   logic [18:0]          ang_res;

   assign stat.cmd = cmd_ff;

   always_comb begin
      case (ctrl.op)
         OP_SC_X: begin
            mul_a = 33'(vec_x_ff);
            mul_b = 33'(sf_ff);
         end
         OP_SC_Y: begin
            mul_a = 33'(vec_y_ff);
            mul_b = 33'(sf_ff);
         end
         OP_RT_MUL: begin
            mul_a = $signed({2'b0, len_ff});
            mul_b = $signed({3'b0, GAIN_Q30});
         end
         OP_GN_HI: begin
            mul_a = $signed({5'b0, cx_ff[XW-1:32]});
            mul_b = $signed({3'b0, GAIN_Q30});
         end
         OP_GN_LO: begin
            mul_a = $signed({1'b0, cx_ff[31:0]});
            mul_b = $signed({3'b0, GAIN_Q30});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      sc_round = (prod_ff + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      cl_s     = clamp32(sc_round);

      rt_x  = neg_ff ? -cx_ff : cx_ff;
      rt_y  = neg_ff ? -cy_ff : cy_ff;
      rt_rx = (66'(rt_x) + (66'sd1 <<< (GUARD - 1))) >>> GUARD;
      rt_ry = (66'(rt_y) + (66'sd1 <<< (GUARD - 1))) >>> GUARD;

      sum_x = (ctrl.op == OP_SUB) ? 33'(ix_ff) : 33'(ix_ff);
      sum_y = 33'(iy_ff);
      if (ctrl.op == OP_SUB) begin
         sum_x = 33'(vec_x_ff) - 33'(ix_ff);
         sum_y = 33'(vec_y_ff) - 33'(iy_ff);
      end else begin
         sum_x = 33'(vec_x_ff) + 33'(ix_ff);
         sum_y = 33'(vec_y_ff) + 33'(iy_ff);
      end

      if (ctrl.op == OP_RT_DONE) begin
         cl_x = clamp32(rt_rx);
         cl_y = clamp32(rt_ry);
      end else begin
         cl_x = clamp32(66'(sum_x));
         cl_y = clamp32(66'(sum_y));
      end

      xs = cx_ff >>> ctrl.iter;
      ys = cy_ff >>> ctrl.iter;
      at = atan_q30(ctrl.iter);
      z0 = 36'(ang_ff) <<< 14;
      vx0 = 60'(vec_x_ff) <<< GUARD;
      vy0 = 60'(vec_y_ff) <<< GUARD;

      // Final angle: clamp to +-pi, round Q.30 down to Q.16, clamp to the output range.
      zc = cz_ff;
      if (zc > PI_Q30) begin
         zc = PI_Q30;
      end else if (zc < -PI_Q30) begin
         zc = -PI_Q30;
      end
      zr = (zc + 36'sd8192) >>> 14;
      if (zr > ANGLE_MAX) begin
         zr = ANGLE_MAX;
      end else if (zr < -ANGLE_MAX) begin
         zr = -ANGLE_MAX;
      end
      ang_res = zero_ff ? '0 : zr[18:0];

      lsum   = acc_ff + 64'd8388608;
      lshift = lsum[63:24];
      if (zero_ff) begin
         len_res = '0;
      end else if (|lshift[39:32]) begin
         len_res = 32'hFFFFFFFF;
      end else begin
         len_res = lshift[31:0];
      end
   end

   always_comb begin
      vec_x_in = vec_x_ff;
      vec_y_in = vec_y_ff;
      sat_in   = sat_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      cz_in    = cz_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      prod_in  = mul_a * mul_b;
      acc_in   = acc_ff;
      case (ctrl.op)
         OP_LATCH: sat_in = 1'b0;
         OP_LOAD_XY: begin
            vec_x_in = ix_ff;
            vec_y_in = iy_ff;
         end
         OP_ADD, OP_SUB, OP_RT_DONE: begin
            vec_x_in = $signed(cl_x[31:0]);
            vec_y_in = $signed(cl_y[31:0]);
            sat_in   = sat_ff | cl_x[32] | cl_y[32];
         end
         OP_SC_Y: begin
            vec_x_in = $signed(cl_s[31:0]);
            sat_in   = sat_ff | cl_s[32];
         end
         OP_SC_W: begin
            vec_y_in = $signed(cl_s[31:0]);
            sat_in   = sat_ff | cl_s[32];
         end
         OP_RT_INIT: begin
            cx_in = XW'(prod_ff >>> 6);
            cy_in = '0;
            if (z0 > HALF_PI_Q30) begin
               cz_in  = z0 - PI_Q30;
               neg_in = 1'b1;
            end else if (z0 < -HALF_PI_Q30) begin
               cz_in  = z0 + PI_Q30;
               neg_in = 1'b1;
            end else begin
               cz_in  = z0;
               neg_in = 1'b0;
            end
         end
         OP_RT_ITER: begin
            if (cz_ff >= 0) begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               cz_in = cz_ff - at;
            end else begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               cz_in = cz_ff + at;
            end
         end
         OP_VC_INIT: begin
            zero_in = (vec_x_ff == 0) && (vec_y_ff == 0);
            // A vector in the left half plane is first turned by pi.
            if (vec_x_ff < 0) begin
               cx_in = -vx0;
               cy_in = -vy0;
               cz_in = (vec_y_ff >= 0) ? PI_Q30 : -PI_Q30;
            end else begin
               cx_in = vx0;
               cy_in = vy0;
               cz_in = '0;
            end
         end
         OP_VC_ITER: begin
            if (cy_ff > 0) begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               cz_in = cz_ff + at;
            end else begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               cz_in = cz_ff - at;
            end
         end
         OP_GN_LO: acc_in = {prod_ff[61:0], 2'b00};
         OP_GN_SUM: acc_in = acc_ff + ((prod_ff[63:0] + 64'd536870912) >> 30);
         default: acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_x_ff <= '0;
         vec_y_ff <= '0;
      end else begin
         vec_x_ff <= vec_x_in;
         vec_y_ff <= vec_y_in;
      end
   end

   always_ff @(posedge clock) begin
      sat_ff  <= sat_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cz_ff   <= cz_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (ctrl.op == OP_LATCH) begin
         cmd_ff <= req_tuser;
         ix_ff  <= $signed(req_tdata[31:0]);
         iy_ff  <= $signed(req_tdata[63:32]);
         ang_ff <= $signed(req_tdata[82:64]);
         len_ff <= req_tdata[113:83];
         sf_ff  <= $signed(req_tdata[145:114]);
      end
      if (ctrl.op == OP_OUT) begin
         ox_ff   <= vec_x_ff;
         oy_ff   <= vec_y_ff;
         olen_ff <= len_res;
         oang_ff <= ang_res;
         osat_ff <= sat_ff;
      end
   end

   assign rsp_tdata = {5'b0, oang_ff, olen_ff, oy_ff, ox_ff};
   assign rsp_tuser = osat_ff;

endmodule

@@ src/vector_polar_accumulator.sv @@
// Vector polar accumulator: holds one Q16.16 vector, applies one command per
// request and returns x, y, length and angle. A new request is not taken until the
// one before it has reached the result register. The single CORDIC stage runs one
// iteration per cycle, and the shared multiplier is used for scaling and gain
// correction. A finished result waits in its own register, so the next request is
// taken while it is still pending.
// Depends on vpa_pkg, vpa_ctrl and vpa_datapath.
module vector_polar_accumulator #(
   parameter int CORDIC_ITERATIONS = 16,
   parameter int FRAC_BITS         = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [151:0] req_tdata,  // in_x, in_y, in_angle, in_length, scale_factor
   input  logic [2:0]   req_tuser,  // cmd
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,  // out_x, out_y, out_length, out_angle
   output logic         rsp_tuser   // saturated
);
   import vpa_pkg::*;

   dp_ctrl_type ctrl;
   dp_stat_type stat;

   vpa_ctrl #(
      .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctrl       (ctrl),
      .stat       (stat)
   );

   vpa_datapath #(
      .FRAC_BITS(FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .ctrl      (ctrl),
      .stat      (stat),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

@@ test/vpa_checker.sv @@
// Request/response checker of the vector polar accumulator: predicts every response
// from the accepted requests and compares it field by field. Depends on vpa_pkg.
`timescale 1ns / 100ps

module vpa_checker #(
   parameter int CORDIC_ITERATIONS = 16,
   parameter int FRAC_BITS         = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [151:0] req_tdata,
   input  logic [2:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [119:0] rsp_tdata,
   input  logic         rsp_tuser,
   output int           fail_count,
   output int           pending_count
);
   import vpa_pkg::*;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [31:0]        length;
      logic signed [18:0] angle;
      logic               sat;
   } vector_report_type;

   localparam longint ATAN_TABLE [30] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
      64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};

   logic signed [31:0] held_x, held_y;
   vector_report_type  expected_reports[$];
   int                 mismatches;

   assign fail_count    = mismatches;
   assign pending_count = expected_reports.size();

   function automatic logic signed [31:0] clamp32(input longint v, inout logic sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 32'sh7FFFFFFF;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] round_clamp(input longint v, input int n,
                                                      inout logic sat);
      return clamp32((v + (64'sd1 <<< (n - 1))) >>> n, sat);
   endfunction

   // Length and angle by CORDIC vectoring, with guard bits and the fixed gain.
   function automatic void measure(input logic signed [31:0] px, input logic signed [31:0] py,
                                   output logic [31:0] len, output logic signed [18:0] ang);
      longint x, y, z, xs, ys;
      longint unsigned u, a, b, prod, l;
      x = longint'(px) * (64'sd1 <<< GUARD);
      y = longint'(py) * (64'sd1 <<< GUARD);
      z = 0;
      if (px == 0 && py == 0) begin
         len = '0;
         ang = '0;
         return;
      end
      if (x < 0) begin
         z = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_ITERATIONS && i < TABLE_LEN; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; z += ATAN_TABLE[i];
         end else begin
            x -= ys; y += xs; z -= ATAN_TABLE[i];
         end
      end
      u    = x;
      a    = u >> 32;
      b    = u & 64'hFFFFFFFF;
      prod = a * longint'(GAIN_Q30) * 4 + ((b * longint'(GAIN_Q30) + (64'd1 << 29)) >> 30);
      l    = (prod + (64'd1 << (GUARD - 1))) >> GUARD;
      len  = (l > 64'hFFFFFFFF) ? 32'hFFFFFFFF : l[31:0];
      if (z > longint'(PI_Q30)) z = PI_Q30;
      if (z < -longint'(PI_Q30)) z = -longint'(PI_Q30);
      z = (z + (64'sd1 <<< 13)) >>> 14;
      if (z > longint'(ANGLE_MAX)) z = ANGLE_MAX;
      if (z < -longint'(ANGLE_MAX)) z = -longint'(ANGLE_MAX);
      ang = z[18:0];
   endfunction

   // Polar load by CORDIC rotation; angles past a right angle are folded by pi.
   function automatic void place_polar(input logic signed [18:0] ang19,
                                       input logic [30:0] length, inout logic sat);
      longint x, y, z, xs, ys;
      logic   flip;
      z    = longint'(ang19) * 16384;
      x    = (longint'(length) * longint'(GAIN_Q30)) >>> (30 - GUARD);
      y    = 0;
      flip = 1'b0;
      if (z > longint'(HALF_PI_Q30)) begin
         z -= PI_Q30; flip = 1'b1;
      end else if (z < -longint'(HALF_PI_Q30)) begin
         z += PI_Q30; flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_ITERATIONS && i < TABLE_LEN; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= ATAN_TABLE[i];
         end else begin
            x += ys; y -= xs; z += ATAN_TABLE[i];
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      held_x = round_clamp(x, GUARD, sat);
      held_y = round_clamp(y, GUARD, sat);
   endfunction

   function automatic vector_report_type apply_command(input logic [2:0] cmd,
                                                       input logic [151:0] d);
      logic signed [31:0] in_x, in_y, factor;
      logic signed [18:0] in_angle;
      logic [30:0]        in_length;
      vector_report_type  r;
      logic               sat;
      in_x      = d[31:0];
      in_y      = d[63:32];
      in_angle  = d[82:64];
      in_length = d[113:83];
      factor    = d[145:114];
      sat       = 1'b0;
      case (cmd)
         CMD_LOAD_XY: begin
            held_x = in_x;
            held_y = in_y;
         end
         CMD_LOAD_POLAR: place_polar(in_angle, in_length, sat);
         CMD_ADD: begin
            held_x = clamp32(longint'(held_x) + longint'(in_x), sat);
            held_y = clamp32(longint'(held_y) + longint'(in_y), sat);
         end
         CMD_SUB: begin
            held_x = clamp32(longint'(held_x) - longint'(in_x), sat);
            held_y = clamp32(longint'(held_y) - longint'(in_y), sat);
         end
         CMD_SCALE: begin
            held_x = round_clamp(longint'(held_x) * longint'(factor), FRAC_BITS, sat);
            held_y = round_clamp(longint'(held_y) * longint'(factor), FRAC_BITS, sat);
         end
         default: ;
      endcase
      r.x = held_x;
      r.y = held_y;
      measure(held_x, held_y, r.length, r.angle);
      r.sat = sat;
      return r;
   endfunction

   always @(posedge clock) begin
      vector_report_type want, got;
      if (reset) begin
         held_x = '0;
         held_y = '0;
         expected_reports.delete();
         mismatches <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_reports.push_back(apply_command(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.x      = rsp_tdata[31:0];
            got.y      = rsp_tdata[63:32];
            got.length = rsp_tdata[95:64];
            got.angle  = rsp_tdata[114:96];
            got.sat    = rsp_tuser;
            if (expected_reports.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: response with nothing expected: x=%h y=%h", $realtime,
                           got.x, got.y);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_reports.pop_front();
               if (want !== got) begin
                  if (mismatches < 10)
                     $display("%0t: exp/act x %h/%h y %h/%h len %h/%h ang %h/%h sat %b/%b",
                              $realtime, want.x, got.x, want.y, got.y, want.length,
                              got.length, want.angle, got.angle, want.sat, got.sat);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end

endmodule

@@ test/tb_top.sv @@
// Top of the vector polar accumulator testbench: clock, reset, request stimulus and
// response stalls, with vpa_checker judging the responses. Depends on vpa_pkg.
`timescale 1ns / 100ps

module tb_top;
   import vpa_pkg::*;

   localparam logic [2:0] CMD_SPARE_A = 3'd5;
   localparam logic [2:0] CMD_SPARE_B = 3'd6;
   localparam logic [2:0] CMD_SPARE_C = 3'd7;
   localparam int         RANDOM_REQUESTS = 1200;
   localparam int         IDLE_LIMIT      = 2000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [151:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [119:0] rsp_tdata;
   logic         rsp_tuser;
   int           fail_count, pending_count;
   int           idle_cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   vector_polar_accumulator dut (.*);
   vpa_checker checker_inst (.*);

   // The receiver switches at random among four stall modes.
   int stall_mode = 0, mode_cycles = 0;
   always @(posedge clock) begin
      if (mode_cycles == 0) begin
         stall_mode  <= $urandom_range(0, 3);
         mode_cycles <= $urandom_range(50, 400);
      end else
         mode_cycles <= mode_cycles - 1;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 9) < 7);
         2: rsp_tready <= (mode_cycles % 5 == 0);
         default: rsp_tready <= ($urandom_range(0, 9) < 2);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send(input logic [2:0] cmd, input logic [31:0] x, input logic [31:0] y,
                       input logic [18:0] angle, input logic [30:0] length,
                       input logic [31:0] factor);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {6'b0, factor, length, angle, y, x};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic pause(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_component();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 3)
                                         : 32'h80000000 + $urandom_range(0, 3);
         default: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
      endcase
   endfunction

   initial begin
      logic [2:0]  cmd;
      logic [31:0] factor;
      int          burst;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(CMD_LOAD_XY, 32'h0, 32'h0, 19'h0, 31'h0, 32'h0);          // zero vector
      send(CMD_LOAD_XY, 32'h7FFFFFFF, 32'h80000000, 19'h0, 31'h0, 32'h0);
      send(CMD_ADD, 32'h7FFFFFFF, 32'h80000000, 19'h0, 31'h0, 32'h0);
      send(CMD_SUB, 32'h80000000, 32'h7FFFFFFF, 19'h0, 31'h0, 32'h0);
      send(CMD_SCALE, 32'h0, 32'h0, 19'h0, 31'h0, 32'h7FFFFFFF);
      send(CMD_LOAD_XY, 32'hFFFF0000, 32'h0, 19'h0, 31'h0, 32'h0);    // negative x on axis
      send(CMD_LOAD_XY, 32'hFFFF0000, 32'hFFFFFFFF, 19'h0, 31'h0, 32'h0);
      send(CMD_LOAD_XY, 32'h80000000, 32'h80000000, 19'h0, 31'h0, 32'h0);
      send(CMD_SCALE, 32'h0, 32'h0, 19'h0, 31'h0, 32'h80000000);
      send(CMD_LOAD_XY, 32'h00000003, 32'hFFFFFFFD, 19'h0, 31'h0, 32'h0);
      send(CMD_SCALE, 32'h0, 32'h0, 19'h0, 31'h0, 32'h00008000);      // rounding at half
      send(CMD_LOAD_POLAR, 32'h0, 32'h0, 19'h0, 31'h7FFFFFFF, 32'h0);
      send(CMD_LOAD_POLAR, 32'h0, 32'h0, 19'd102944, 31'h00010000, 32'h0);
      send(CMD_LOAD_POLAR, 32'h0, 32'h0, -19'sd102944, 31'h00010000, 32'h0);
      send(CMD_LOAD_POLAR, 32'h0, 32'h0, 19'd205887, 31'h7FFFFFFF, 32'h0);
      send(CMD_LOAD_POLAR, 32'h0, 32'h0, -19'sd205887, 31'h7FFFFFFF, 32'h0);
      send(CMD_LOAD_POLAR, 32'h0, 32'h0, 19'h3FFFF, 31'h00123456, 32'h0);
      send(CMD_LOAD_POLAR, 32'h0, 32'h0, 19'h40000, 31'h00123456, 32'h0);
      send(CMD_LOAD_POLAR, 32'h0, 32'h0, 19'h0, 31'h0, 32'h0);
      send(CMD_SPARE_A, 32'hFFFFFFFF, 32'hFFFFFFFF, 19'h7FFFF, 31'h7FFFFFFF, 32'hFFFFFFFF);
      send(CMD_SPARE_B, 32'h0, 32'h0, 19'h0, 31'h0, 32'h0);
      send(CMD_SPARE_C, 32'h0, 32'h0, 19'h0, 31'h0, 32'h0);

      burst = 0;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 20);
            if ($urandom_range(0, 2) != 0)
               pause($urandom_range(1, 30));
         end
         burst--;
         cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(CMD_SPARE_A, CMD_SPARE_C))
                                            : 3'($urandom_range(CMD_LOAD_XY, CMD_SCALE));
         case ($urandom_range(0, 3))
            0: factor = $urandom;
            1: factor = {{14{$urandom_range(0, 1) == 1}}, 18'($urandom)};
            default: factor = 32'h00010000 + $urandom_range(0, 8191) - 4096;
         endcase
         send(cmd, pick_component(), pick_component(),
              ($urandom_range(0, 3) == 0) ? 19'($urandom)
                                          : 19'($urandom_range(0, 411774) - 205887),
              ($urandom_range(0, 1) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 24)),
              factor);
      end
      req_tvalid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
